[hw/rtl/utf8_to_cesu8_transcoder_unit_macros.svh]
// Assertion macros for the UTF-8 to CESU-8 transcoder checker.
`ifndef UTF8_TO_CESU8_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_CESU8_TRANSCODER_UNIT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define U2C_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("u2c assertion failed");

// Same, bound to the usual clock and reset names of this block.
`define U2C_ASSERT_STD(name, prop) \
  `U2C_ASSERT(name, clk_i, rst_ni, prop)

`endif

[hw/rtl/u2c_pkg.sv]
// Package with the shared types and constants of the UTF-8 to CESU-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u2c_pkg;

  // Default number of entries in the queue between front and back end.
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [15:0] ReplacementCode = 16'hFFFD;
  localparam logic [15:0] HighSurrogateBias = 16'hD7C0;
  localparam logic [5:0] LowSurrogateTop = 6'b110111;

  // One classified item: replacement characters flushed before the main
  // codes, zero to two main codes, replacement characters flushed after.
  typedef struct packed {
    logic [1:0]  n_pre;
    logic [1:0]  main_cnt;
    logic [15:0] code_a;
    logic [15:0] code_b;
    logic [1:0]  n_post;
    logic        last;
  } u2c_job_t;

endpackage

`default_nettype wire

[hw/rtl/u2c_if.sv]
// Valid/ready channel interfaces for the UTF-8 input and the CESU-8 output.
`timescale 1ns / 1ps
`default_nettype none

interface u2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface u2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  logic       end_of_stream;

  modport source (output valid, output out_byte, output end_of_run,
                  output end_of_stream, input ready);
  modport sink (input valid, input out_byte, input end_of_run,
                input end_of_stream, output ready);
endinterface

`default_nettype wire

[hw/rtl/u2c_front.sv]
// Front end: accepts input bytes, tracks held sequences and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module u2c_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  u2c_in_if.sink           in_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output u2c_pkg::u2c_job_t job_o
);

  logic [1:0] held_cnt_q, held_cnt_d;
  logic [7:0] lead_q, lead_d;
  logic [5:0] c0_q, c0_d, c1_q, c1_d;
  logic       accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  always_comb begin
    logic [7:0]  b;
    logic        is_cont;
    logic [2:0]  need;
    logic [20:0] v4;
    logic [2:0]  total;
    b       = in_i.in_byte;
    is_cont = (b[7:6] == 2'b10);
    need    = (lead_q < 8'hE0) ? 3'd2 : ((lead_q < 8'hF0) ? 3'd3 : 3'd4);
    v4      = {lead_q[2:0], c0_q, c1_q, b[5:0]};

    held_cnt_d     = held_cnt_q;
    lead_d         = lead_q;
    c0_d           = c0_q;
    c1_d           = c1_q;
    job_o.n_pre    = 2'd0;
    job_o.main_cnt = 2'd0;
    job_o.code_a   = u2c_pkg::ReplacementCode;
    job_o.code_b   = u2c_pkg::ReplacementCode;
    job_o.n_post   = 2'd0;
    job_o.last     = in_i.is_last;

    if ((held_cnt_q != 2'd0) && is_cont) begin
      if ({1'b0, held_cnt_q} + 3'd1 == need) begin
        held_cnt_d     = 2'd0;
        job_o.main_cnt = 2'd1;
        if (need == 3'd2) begin
          job_o.code_a = {5'd0, lead_q[4:0], b[5:0]};
        end else if (need == 3'd3) begin
          job_o.code_a = {lead_q[3:0], c0_q, b[5:0]};
        end else if (v4[20:16] != 5'd0) begin
          // Supplementary value: split into a surrogate pair.
          job_o.main_cnt = 2'd2;
          job_o.code_a   = u2c_pkg::HighSurrogateBias + {5'd0, v4[20:10]};
          job_o.code_b   = {u2c_pkg::LowSurrogateTop, v4[9:0]};
        end else begin
          // Overlong four-byte value keeps only the low surrogate.
          job_o.code_a = {u2c_pkg::LowSurrogateTop, v4[9:0]};
        end
      end else begin
        if (held_cnt_q == 2'd1) begin
          c0_d = b[5:0];
        end else begin
          c1_d = b[5:0];
        end
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end else begin
      job_o.n_pre = held_cnt_q;
      held_cnt_d  = 2'd0;
      if (b < 8'h80) begin
        job_o.main_cnt = 2'd1;
        job_o.code_a   = {8'd0, b};
      end else if (b >= 8'hC0 && b < 8'hF8) begin
        lead_d     = b;
        held_cnt_d = 2'd1;
      end else begin
        job_o.main_cnt = 2'd1;
      end
    end

    if (in_i.is_last) begin
      job_o.n_post = held_cnt_d;
      held_cnt_d   = 2'd0;
    end

    total  = {1'b0, job_o.n_pre} + {1'b0, job_o.main_cnt} + {1'b0, job_o.n_post};
    push_o = accept && (total != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lead_q <= lead_d;
      c0_q   <= c0_d;
      c1_q   <= c1_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/u2c_queue.sv]
// Short first-in first-out queue of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module u2c_queue #(
  parameter int unsigned Depth = u2c_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire u2c_pkg::u2c_job_t job_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output u2c_pkg::u2c_job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2c_pkg::u2c_job_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/u2c_back.sv]
// Back end: expands each classified item into CESU-8 bytes, one byte per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module u2c_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  wire u2c_pkg::u2c_job_t job_i,
  output logic                   pop_o,
  u2c_out_if.source              out_o
);

  logic [1:0] sym_q, byt_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       eor_q, eos_q;
  logic       step;
  logic       last_byte, last_sym;
  logic [7:0] cur_byte;

  always_comb begin
    logic [2:0]  s;
    logic [2:0]  rel;
    logic [2:0]  total;
    logic [15:0] code;
    logic [1:0]  len_m1;
    s     = {1'b0, sym_q};
    rel   = s - {1'b0, job_i.n_pre};
    total = {1'b0, job_i.n_pre} + {1'b0, job_i.main_cnt} + {1'b0, job_i.n_post};

    // Symbols run: leading replacements, main codes, trailing replacements.
    if (s < {1'b0, job_i.n_pre}) begin
      code = u2c_pkg::ReplacementCode;
    end else if (rel < {1'b0, job_i.main_cnt}) begin
      code = (rel == 3'd0) ? job_i.code_a : job_i.code_b;
    end else begin
      code = u2c_pkg::ReplacementCode;
    end

    if (code < 16'h0080) begin
      len_m1   = 2'd0;
      cur_byte = code[7:0];
    end else if (code < 16'h0800) begin
      len_m1   = 2'd1;
      cur_byte = (byt_q == 2'd0) ? {3'b110, code[10:6]} : {2'b10, code[5:0]};
    end else begin
      len_m1 = 2'd2;
      case (byt_q)
        2'd0:    cur_byte = {4'b1110, code[15:12]};
        2'd1:    cur_byte = {2'b10, code[11:6]};
        default: cur_byte = {2'b10, code[5:0]};
      endcase
    end

    last_byte = (byt_q == len_m1);
    last_sym  = (s == total - 3'd1);
  end

  assign step  = job_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = step && last_byte && last_sym;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q       <= 2'd0;
      byt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        if (last_byte) begin
          byt_q <= 2'd0;
          sym_q <= last_sym ? 2'd0 : sym_q + 2'd1;
        end else begin
          byt_q <= byt_q + 2'd1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= cur_byte;
      eor_q      <= last_byte && last_sym;
      eos_q      <= last_byte && last_sym && job_i.last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.end_of_run    = eor_q;
  assign out_o.end_of_stream = eos_q;

endmodule

`default_nettype wire

[hw/rtl/utf8_to_cesu8_transcoder_unit.sv]
// Top level of the UTF-8 to CESU-8 transcoder.
//
// The block takes a UTF-8 byte stream on in_i, one byte per item with an
// is_last flag, and gives the CESU-8 stream on out_o, one byte per item.
// Both channels use valid/ready; an item moves when both are high at a
// rising clock edge. Each input item causes zero to twelve output bytes;
// the last of them carries end_of_run, and after an input marked is_last
// it also carries end_of_stream. A lead byte or an unfinished sequence
// causes no output until the sequence completes or breaks.
// The front end takes one input item per cycle whenever the item queue
// (QueueDepth entries) has room. The back end sends one output byte per
// cycle while the receiver is ready and the queue holds an item. The first
// byte of an item passes through the queue and then the output register.
// When the receiver stalls, the output register holds its byte, the back
// end waits, and the queue fills before in_i.ready drops.
// Reset clears the held sequence, the queue and the output register; the
// block accepts items as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_cesu8_transcoder_unit #(
  parameter int unsigned QueueDepth = u2c_pkg::QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  u2c_in_if.sink    in_i,
  u2c_out_if.source out_o
);

  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;
  u2c_pkg::u2c_job_t push_job;
  u2c_pkg::u2c_job_t head_job;

  // Front end: decodes the byte against the held sequence into a job.
  u2c_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Queue decouples classification from byte emission.
  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Back end: serializes the job into encoded bytes.
  u2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[hw/rtl/u2c_checker.sv]
// Checker on the output port of the transcoder, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_cesu8_transcoder_unit_macros.svh"

module u2c_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       end_of_run_i,
  input wire logic       end_of_stream_i
);

  `U2C_ASSERT_STD(a_valid_holds, out_valid_i && !out_ready_i |=> out_valid_i)
  `U2C_ASSERT_STD(a_byte_holds, out_valid_i && !out_ready_i |=> $stable(out_byte_i))
  // CESU-8 never needs a four-byte lead, so no byte reaches F0.
  `U2C_ASSERT_STD(a_no_f_byte, out_valid_i |-> out_byte_i[7:4] != 4'hF)
  // A run ends on a complete character, never on a lead byte, and the
  // stream end is always a run end.
  `U2C_ASSERT_STD(a_run_end, out_valid_i && end_of_run_i |-> out_byte_i[7:6] != 2'b11)
  `U2C_ASSERT_STD(a_eos_eor, out_valid_i && end_of_stream_i |-> end_of_run_i)

endmodule

bind utf8_to_cesu8_transcoder_unit u2c_checker u_u2c_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.out_byte),
  .end_of_run_i    (out_o.end_of_run),
  .end_of_stream_i (out_o.end_of_stream)
);

`default_nettype wire
